// ===== hw/rtl/e2cal_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds shared constants and the month length table; no dependencies.
package e2cal_pkg;

  localparam int unsigned SecsW       = 32;
  localparam int unsigned DaysW       = 16;   // whole days fit in 16 bits
  localparam int unsigned AccW        = 18;   // shared subtractor width
  localparam int unsigned YearW       = 12;
  localparam int unsigned MulAW       = 25;   // shared multiplier operands
  localparam int unsigned MulBW       = 26;
  localparam int unsigned ProdW       = MulAW + MulBW;

  localparam logic [MulBW-1:0] SecsPerDay  = 26'd86400;
  localparam logic [MulBW-1:0] SecsPerHour = 26'd3600;
  localparam logic [MulBW-1:0] SecsPerMin  = 26'd60;
  localparam logic [MulBW-1:0] DaysPerWeek = 26'd7;
  // Reciprocals, exact over the operand range:
  // (s >> 7) / 675 = (x * DayRecip) >> 35, x < 2^25
  // (sod >> 4) / 225 = (x * HourRecip) >> 21, x < 2^13
  // (mos >> 2) / 15 = (x * MinRecip) >> 14, x < 2^10
  // x / 7 = (x * WeekRecip) >> 19, x < 2^16
  localparam logic [MulBW-1:0] DayRecip    = 26'd50903317;
  localparam logic [MulBW-1:0] HourRecip   = 26'd9321;
  localparam logic [MulBW-1:0] MinRecip    = 26'd1093;
  localparam logic [MulBW-1:0] WeekRecip   = 26'd74899;
  localparam logic [AccW-1:0]  DaysCommon  = 18'd365;
  localparam logic [AccW-1:0]  DaysLeap    = 18'd366;
  localparam logic [YearW-1:0] BaseYear    = 12'd1970;
  // Only century year in range that is not divisible by 400
  localparam logic [YearW-1:0] SkipLeapYear = 12'd2100;
  localparam logic [3:0]       LastMonthIdx = 4'd11;
  localparam logic [DaysW:0]   WeekdayOffset = 17'd4;  // 1970-01-01 was a Thursday

  function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
    logic [4:0] len;
    case (mi)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Epoch seconds to Gregorian calendar converter, top level.
// Depends on e2cal_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | start / busy       | in_epoch_seconds
//  out     | out_valid (strobe) | out_year, out_month, out_day_of_month,
//          |                    | out_hours, out_minutes, out_secs, out_weekday
//
// One item runs S_DAYQ to S_WDAYR, reciprocal multiply and subtract on the
// shared multiplier for the divisions by 86400, 3600, 60 and 7, then S_YEAR
// and S_MONTH, which take one year and one month off per cycle by the
// subtractor. No new item is taken while busy.
// busy is high from acceptance until the cycle out_valid pulses.
// Synchronous active-low reset returns the sequencer to idle.
// The receiver cannot stall; results are held on the ports until the next item.
module epoch_seconds_to_calendar
  import e2cal_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [31:0]      in_epoch_seconds,
  output logic             out_valid,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hours,
  output logic [5:0]       out_minutes,
  output logic [5:0]       out_secs,
  output logic [2:0]       out_weekday
);

  typedef enum logic [3:0] {
    S_IDLE, S_DAYQ, S_DAYR, S_HOURQ, S_HOURR, S_MINQ, S_MINR,
    S_WDAYQ, S_WDAYR, S_YEAR, S_MONTH
  } state_t;

  state_t            state_r, state_nxt;
  logic [SecsW-1:0]  q_r, q_nxt;
  logic [DaysW-1:0]  quo_r, quo_nxt;
  logic [AccW-1:0]   r_r, r_nxt;
  logic [DaysW-1:0]  days_r, days_nxt;
  logic [YearW-1:0]  year_r, year_nxt;
  logic [3:0]        mi_r, mi_nxt;
  logic [4:0]        hours_r, hours_nxt;
  logic [5:0]        minutes_r, minutes_nxt;
  logic [5:0]        secs_r, secs_nxt;
  logic [2:0]        weekday_r, weekday_nxt;
  logic              valid_r, valid_nxt;
  logic [11:0]       oyear_r, oyear_nxt;
  logic [3:0]        omonth_r, omonth_nxt;
  logic [4:0]        oday_r, oday_nxt;
  logic [4:0]        ohours_r, ohours_nxt;
  logic [5:0]        ominutes_r, ominutes_nxt;
  logic [5:0]        osecs_r, osecs_nxt;
  logic [2:0]        oweekday_r, oweekday_nxt;

  // shared multiplier and subtractor
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  prod;
  logic [AccW-1:0]   sub_a, sub_b;
  logic [AccW:0]     diff;
  logic              ge;
  logic              leap;
  logic [DaysW:0]    days_off;

  assign prod     = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = ~diff[AccW];
  assign leap     = (year_r[1:0] == 2'b00) && (year_r != SkipLeapYear);
  assign days_off = {1'b0, days_r} + WeekdayOffset;

  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    quo_nxt      = quo_r;
    r_nxt        = r_r;
    days_nxt     = days_r;
    year_nxt     = year_r;
    mi_nxt       = mi_r;
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    secs_nxt     = secs_r;
    weekday_nxt  = weekday_r;
    valid_nxt    = 1'b0;
    oyear_nxt    = oyear_r;
    omonth_nxt   = omonth_r;
    oday_nxt     = oday_r;
    ohours_nxt   = ohours_r;
    ominutes_nxt = ominutes_r;
    osecs_nxt    = osecs_r;
    oweekday_nxt = oweekday_r;
    mul_a        = q_r[SecsW-1:7];
    mul_b        = DayRecip;
    sub_a        = r_r;
    sub_b        = DaysCommon;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          q_nxt     = in_epoch_seconds;
          state_nxt = S_DAYQ;
        end
      end
      // quotient states multiply by a reciprocal, remainder states take
      // quotient * divisor off the dividend
      S_DAYQ: begin
        mul_a     = q_r[SecsW-1:7];
        mul_b     = DayRecip;
        quo_nxt   = prod[50:35];
        state_nxt = S_DAYR;
      end
      S_DAYR: begin
        mul_a     = {9'b0, quo_r};
        mul_b     = SecsPerDay;
        sub_a     = q_r[AccW-1:0];
        sub_b     = prod[AccW-1:0];
        days_nxt  = quo_r;
        q_nxt     = {14'b0, diff[AccW-1:0]};
        state_nxt = S_HOURQ;
      end
      S_HOURQ: begin
        mul_a     = {12'b0, q_r[16:4]};
        mul_b     = HourRecip;
        quo_nxt   = {11'b0, prod[25:21]};
        state_nxt = S_HOURR;
      end
      S_HOURR: begin
        mul_a     = {9'b0, quo_r};
        mul_b     = SecsPerHour;
        sub_a     = q_r[AccW-1:0];
        sub_b     = prod[AccW-1:0];
        hours_nxt = quo_r[4:0];
        q_nxt     = {14'b0, diff[AccW-1:0]};
        state_nxt = S_MINQ;
      end
      S_MINQ: begin
        mul_a     = {15'b0, q_r[11:2]};
        mul_b     = MinRecip;
        quo_nxt   = {10'b0, prod[19:14]};
        state_nxt = S_MINR;
      end
      S_MINR: begin
        mul_a       = {9'b0, quo_r};
        mul_b       = SecsPerMin;
        sub_a       = q_r[AccW-1:0];
        sub_b       = prod[AccW-1:0];
        minutes_nxt = quo_r[5:0];
        secs_nxt    = diff[5:0];
        q_nxt       = {15'b0, days_off};
        state_nxt   = S_WDAYQ;
      end
      S_WDAYQ: begin
        mul_a     = {9'b0, q_r[DaysW-1:0]};
        mul_b     = WeekRecip;
        quo_nxt   = {2'b0, prod[32:19]};
        state_nxt = S_WDAYR;
      end
      S_WDAYR: begin
        mul_a       = {9'b0, quo_r};
        mul_b       = DaysPerWeek;
        sub_a       = q_r[AccW-1:0];
        sub_b       = prod[AccW-1:0];
        weekday_nxt = diff[2:0];
        r_nxt       = {2'b00, days_r};
        year_nxt    = BaseYear;
        state_nxt   = S_YEAR;
      end
      S_YEAR: begin
        sub_a = r_r;
        sub_b = leap ? DaysLeap : DaysCommon;
        if (ge) begin
          r_nxt    = diff[AccW-1:0];
          year_nxt = year_r + 12'd1;
        end else begin
          mi_nxt    = '0;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        sub_a = r_r;
        sub_b = {13'b0, month_len(mi_r, leap)};
        if ((mi_r == LastMonthIdx) || !ge) begin
          valid_nxt    = 1'b1;
          oyear_nxt    = year_r;
          omonth_nxt   = mi_r + 4'd1;
          oday_nxt     = r_r[4:0] + 5'd1;
          ohours_nxt   = hours_r;
          ominutes_nxt = minutes_r;
          osecs_nxt    = secs_r;
          oweekday_nxt = weekday_r;
          state_nxt    = S_IDLE;
        end else begin
          r_nxt  = diff[AccW-1:0];
          mi_nxt = mi_r + 4'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    q_r        <= q_nxt;
    quo_r      <= quo_nxt;
    r_r        <= r_nxt;
    days_r     <= days_nxt;
    year_r     <= year_nxt;
    mi_r       <= mi_nxt;
    hours_r    <= hours_nxt;
    minutes_r  <= minutes_nxt;
    secs_r     <= secs_nxt;
    weekday_r  <= weekday_nxt;
    oyear_r    <= oyear_nxt;
    omonth_r   <= omonth_nxt;
    oday_r     <= oday_nxt;
    ohours_r   <= ohours_nxt;
    ominutes_r <= ominutes_nxt;
    osecs_r    <= osecs_nxt;
    oweekday_r <= oweekday_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = valid_r;
  assign out_year         = oyear_r;
  assign out_month        = omonth_r;
  assign out_day_of_month = oday_r;
  assign out_hours        = ohours_r;
  assign out_minutes      = ominutes_r;
  assign out_secs         = osecs_r;
  assign out_weekday      = oweekday_r;

endmodule
